### rtl/puo_pkg.sv
// Shared types and constants for the UTC offset parser.
`timescale 1ns / 1ps
package puo_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;
  localparam int unsigned CountW  = 4;
  localparam int unsigned OffW    = 18;
  localparam int unsigned HmW     = 11;
  localparam int unsigned MagW    = 17;
  localparam int unsigned OutDataW = 24;

  localparam logic [CharW-1:0] ChZ     = 8'h5A;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChColon = 8'h3A;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  localparam logic [6:0] MaxHour = 7'd23;
  localparam logic [6:0] MaxMinSec = 7'd59;

  typedef enum logic [3:0] {
    PH_FIRST = 4'd0,
    PH_H1    = 4'd1,
    PH_H2    = 4'd2,
    PH_SEPM  = 4'd3,
    PH_M1    = 4'd4,
    PH_M2    = 4'd5,
    PH_SEPS  = 4'd6,
    PH_S1    = 4'd7,
    PH_S2    = 4'd8,
    PH_DONE  = 4'd9
  } phase_e;

  // One finished parse, handed from the front to the back.
  typedef struct packed {
    logic              ok;
    logic              neg;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
    logic [CountW-1:0] count;
  } rec_t;

endpackage

### rtl/puo_front.sv
// Character front end: runs the offset parser and emits one record per string.
`timescale 1ns / 1ps
module puo_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     colon_i,
  input  logic                     char_valid_i,
  output logic                     char_ready_o,
  input  logic [puo_pkg::CharW-1:0] char_i,
  input  logic                     last_i,
  output logic                     rec_push_o,
  output puo_pkg::rec_t            rec_o,
  input  logic                     rec_full_i
);
  import puo_pkg::*;

  phase_e            phase_q, phase_d, ph_take;
  logic              failed_q, failed_d, fail_take;
  logic              neg_q, neg_d, neg_take;
  logic [HourW-1:0]  hour_q, hour_d, hour_take;
  logic [MinW-1:0]   min_q, min_d, min_take;
  logic [SecW-1:0]   sec_q, sec_d, sec_take;
  logic [3:0]        tens_q, tens_d, tens_take;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_take;

  logic              fire;
  logic              dig;
  logic [3:0]        d;
  logic [6:0]        two;
  logic              is_colon;

  assign char_ready_o = !rec_full_i;
  assign fire         = char_valid_i && char_ready_o;

  assign dig      = (char_i >= ChZero) && (char_i <= ChNine);
  assign d        = 4'(char_i - ChZero);
  assign two      = {tens_q, 3'b000} + {2'b00, tens_q, 1'b0} + {3'b000, d};
  assign is_colon = colon_i && (char_i == ChColon);

  // Next phase for the current character.
  always_comb begin
    ph_take   = phase_q;
    fail_take = failed_q;
    if (!failed_q) begin
      unique case (phase_q)
        PH_FIRST: begin
          if (char_i == ChZ) ph_take = PH_DONE;
          else if (char_i == ChPlus || char_i == ChMinus) ph_take = PH_H1;
          else fail_take = 1'b1;
        end
        PH_H1: begin
          if (dig) ph_take = PH_H2;
          else fail_take = 1'b1;
        end
        PH_H2: begin
          if (dig && two <= MaxHour) ph_take = PH_SEPM;
          else fail_take = 1'b1;
        end
        PH_SEPM: begin
          if (is_colon) ph_take = PH_M1;
          else if (dig) ph_take = PH_M2;
          else ph_take = PH_DONE;
        end
        PH_SEPS: begin
          if (is_colon) ph_take = PH_S1;
          else if (dig) ph_take = PH_S2;
          else ph_take = PH_DONE;
        end
        PH_M1:   ph_take = dig ? PH_M2 : PH_DONE;
        PH_S1:   ph_take = dig ? PH_S2 : PH_DONE;
        PH_M2:   ph_take = (dig && two <= MaxMinSec) ? PH_SEPS : PH_DONE;
        PH_S2:   ph_take = PH_DONE;
        PH_DONE: ph_take = PH_DONE;
        default: ph_take = phase_q;
      endcase
    end
    phase_d  = phase_q;
    failed_d = failed_q;
    if (fire) begin
      // restart on the final character of each string
      phase_d  = last_i ? PH_FIRST : ph_take;
      failed_d = last_i ? 1'b0 : fail_take;
    end
  end

  // Field values and consumed count for the current character.
  always_comb begin
    neg_take  = neg_q;
    hour_take = hour_q;
    min_take  = min_q;
    sec_take  = sec_q;
    tens_take = tens_q;
    cnt_take  = cnt_q;
    if (!failed_q) begin
      unique case (phase_q)
        PH_FIRST: begin
          if (char_i == ChZ) cnt_take = CountW'(1);
          else if (char_i == ChMinus) neg_take = 1'b1;
          else neg_take = 1'b0;
        end
        PH_H1: if (dig) tens_take = d;
        PH_H2: begin
          if (dig && two <= MaxHour) begin
            hour_take = HourW'(two);
            cnt_take  = CountW'(3);
          end
        end
        PH_SEPM, PH_SEPS: begin
          if (is_colon) cnt_take = cnt_q + CountW'(1);
          else if (dig) tens_take = d;
        end
        PH_M1, PH_S1: if (dig) tens_take = d;
        PH_M2: begin
          if (dig && two <= MaxMinSec) begin
            min_take = MinW'(two);
            cnt_take = cnt_q + CountW'(2);
          end
        end
        PH_S2: begin
          if (dig && two <= MaxMinSec) begin
            sec_take = SecW'(two);
            cnt_take = cnt_q + CountW'(2);
          end
        end
        default: ;
      endcase
    end

    neg_d  = neg_q;
    hour_d = hour_q;
    min_d  = min_q;
    sec_d  = sec_q;
    tens_d = tens_q;
    cnt_d  = cnt_q;
    if (fire) begin
      if (last_i) begin
        neg_d  = 1'b0;
        hour_d = '0;
        min_d  = '0;
        sec_d  = '0;
        tens_d = '0;
        cnt_d  = '0;
      end else begin
        neg_d  = neg_take;
        hour_d = hour_take;
        min_d  = min_take;
        sec_d  = sec_take;
        tens_d = tens_take;
        cnt_d  = cnt_take;
      end
    end

    rec_push_o    = fire && last_i;
    rec_o.ok      = !fail_take && (ph_take >= PH_SEPM);
    rec_o.neg     = neg_take;
    rec_o.hour    = hour_take;
    rec_o.minute  = min_take;
    rec_o.second  = sec_take;
    rec_o.count   = cnt_take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FIRST;
      failed_q <= 1'b0;
      neg_q    <= 1'b0;
      hour_q   <= '0;
      min_q    <= '0;
      sec_q    <= '0;
      tens_q   <= '0;
      cnt_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      failed_q <= failed_d;
      neg_q    <= neg_d;
      hour_q   <= hour_d;
      min_q    <= min_d;
      sec_q    <= sec_d;
      tens_q   <= tens_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### rtl/puo_fifo.sv
// Two-entry queue of parse records between front and back.
`timescale 1ns / 1ps
module puo_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  puo_pkg::rec_t rec_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output puo_pkg::rec_t rec_o
);
  import puo_pkg::*;

  rec_t       mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rec_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

### rtl/puo_back.sv
// Back end: turns a parse record into the signed offset over two stages.
`timescale 1ns / 1ps
module puo_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rec_valid_i,
  input  puo_pkg::rec_t                rec_i,
  output logic                         rec_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [puo_pkg::OutDataW-1:0] out_data_o
);
  import puo_pkg::*;

  // stage A: hours*60 + minutes
  logic              a_valid_q, a_valid_d;
  logic              a_ok_q, a_neg_q;
  logic [HmW-1:0]    a_hm_q;
  logic [SecW-1:0]   a_sec_q;
  logic [CountW-1:0] a_cnt_q;
  logic [HmW-1:0]    hm;

  // output stage
  logic                o_valid_q, o_valid_d;
  logic [OutDataW-1:0] o_data_q;
  logic [MagW-1:0]     mag;
  logic signed [OffW-1:0] off;

  logic o_adv, a_adv;

  assign o_adv     = !o_valid_q || out_ready_i;
  assign a_adv     = !a_valid_q || o_adv;
  assign rec_pop_o = rec_valid_i && a_adv;

  assign hm = {rec_i.hour, 6'b0} - {4'b0, rec_i.hour, 2'b0} + {5'b0, rec_i.minute};

  assign mag = {a_hm_q, 6'b0} - {4'b0, a_hm_q, 2'b0} + {11'b0, a_sec_q};
  assign off = a_neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_comb begin
    a_valid_d = a_adv ? rec_valid_i : a_valid_q;
    o_valid_d = o_adv ? a_valid_q : o_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      a_ok_q  <= rec_i.ok;
      a_neg_q <= rec_i.neg;
      a_hm_q  <= hm;
      a_sec_q <= rec_i.second;
      a_cnt_q <= rec_i.count;
    end
    if (o_adv && a_valid_q) begin
      // a failed parse reports zero everywhere
      if (a_ok_q) o_data_q <= {1'b0, a_cnt_q, off, 1'b1};
      else        o_data_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_data_q;

endmodule

### rtl/parse_utc_offset_top.sv
// Top level of the UTC offset parser: front end, record queue, offset back end.
// Throughput: one character per cycle; the front stalls only when the two-entry
// record queue is full. The result of a string is registered through the queue
// write, the hour-minute stage and the output after its last character is taken.
// Reset: asynchronous, active low; clears parse state, queue, pipeline and mode.
`timescale 1ns / 1ps
module parse_utc_offset_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,    // colon_separator
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [puo_pkg::CharW-1:0]    s_axis_tdata_i, // [7:0] character
  input  logic                         s_axis_tlast_i, // last_char
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [0] parse_ok, [18:1] offset_seconds, [22:19] chars_consumed, [23] zero
  output logic [puo_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import puo_pkg::*;

  logic colon_q, colon_d;
  logic push, full, pop, qvalid;
  rec_t rec_in, rec_out;

  assign colon_d = cfg_we_i ? cfg_wdata_i : colon_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colon_q <= 1'b0;
    end else begin
      colon_q <= colon_d;
    end
  end

  puo_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .colon_i      (colon_q),
    .char_valid_i (s_axis_tvalid_i),
    .char_ready_o (s_axis_tready_o),
    .char_i       (s_axis_tdata_i),
    .last_i       (s_axis_tlast_i),
    .rec_push_o   (push),
    .rec_o        (rec_in),
    .rec_full_i   (full)
  );

  puo_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (qvalid),
    .rec_o   (rec_out)
  );

  puo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (qvalid),
    .rec_i       (rec_out),
    .rec_pop_o   (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

### rtl/puo_checker.sv
// Port-level checks for the UTC offset parser, bound to the top level.
`timescale 1ns / 1ps
module puo_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [puo_pkg::OutDataW-1:0] m_axis_tdata_o
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o == '0)
    else $error("failed parse with nonzero fields");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |->
      m_axis_tdata_o[22:19] != 4'd0 && m_axis_tdata_o[22:19] != 4'd2 &&
      m_axis_tdata_o[22:19] <= 4'd9 && !m_axis_tdata_o[23])
    else $error("consumed count out of range");

  // a bare Z is the only one-character offset
  a_zulu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] && m_axis_tdata_o[22:19] == 4'd1 |->
      m_axis_tdata_o[18:1] == 18'd0)
    else $error("Z offset not zero");

endmodule

bind parse_utc_offset_top puo_checker u_puo_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

### tb/tb_parse_utc_offset_top.sv
// Self-checking testbench for the UTC offset parser: directed strings, then random strings.
`timescale 1ns / 1ps
module tb_parse_utc_offset_top;
  import puo_pkg::*;

  localparam int NumDir      = 12;
  localparam int Pred        = -1;   // row result comes from the predictor
  localparam int SettleCycles = 4;
  localparam int QuietLimit  = 500;
  localparam int RandPhases  = 6;
  localparam int PhaseChars  = 300;

  typedef logic [CharW-1:0] char_q_t[$];

  typedef struct packed {
    logic              ok;
    logic [OffW-1:0]   off;
    logic [CountW-1:0] cnt;
  } offset_res_t;

  typedef struct packed {
    logic        pinned;
    offset_res_t res;
  } typed_offset_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_wdata_i = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [CharW-1:0]    s_axis_tdata_i = '0;   // [7:0] character
  logic                s_axis_tlast_i = 1'b0; // last_char
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // [0] parse_ok, [18:1] offset_seconds, [22:19] chars_consumed, [23] zero
  logic [OutDataW-1:0] m_axis_tdata_o;

  parse_utc_offset_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Directed strings: colon mode, text, and the result where it is obvious.
  string dir_txt   [NumDir] = '{"Z", "Q", "+2", "+24", "-00", "-2359", "+23:59:59",
                                "-12:", "+05:30", "+0161Zx", "+01307", "+0130:5"};
  bit    dir_colon [NumDir] = '{0, 0, 0, 0, 0, 0, 1, 1, 0, 1, 0, 1};
  int    dir_ok    [NumDir] = '{1, 0, 0, 0, 1, 1, 1, 1, Pred, Pred, Pred, Pred};
  int    dir_off   [NumDir] = '{0, 0, 0, 0, 0, -86340, 86399, -43200, 0, 0, 0, 0};
  int    dir_cnt   [NumDir] = '{1, 0, 0, 0, 3, 5, 9, 4, 0, 0, 0, 0};

  // Predictor state
  phase_e            phase;
  logic              neg;
  logic [HourW-1:0]  hours;
  logic [MinW-1:0]   minutes;
  logic [SecW-1:0]   seconds;
  logic [3:0]        tens;
  logic [CountW-1:0] taken;
  logic              bad;
  logic              colon_mode;

  offset_res_t   expected_offsets[$];
  typed_offset_t typed_offsets[$];

  int  errors = 0;
  int  chars_seen = 0;
  int  results_seen = 0;
  int  ok_seen = 0;
  int  mode_writes = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;
  logic cfg_now = 1'b0;

  task automatic clear_parse();
    phase   = PH_FIRST;
    neg     = 1'b0;
    hours   = '0;
    minutes = '0;
    seconds = '0;
    tens    = '0;
    taken   = '0;
    bad     = 1'b0;
  endtask

  task automatic parse_offset_char(input logic [CharW-1:0] c, input logic last,
                                   output logic done, output offset_res_t res);
    logic            dig;
    logic [3:0]      d;
    logic [6:0]      two;
    logic [MagW-1:0] mag;
    logic [OffW-1:0] off;
    dig = (c >= ChZero) && (c <= ChNine);
    d   = c[3:0];
    two = 7'(tens) * 7'd10 + 7'(d);
    if (!bad) begin
      case (phase)
        PH_FIRST: begin
          if (c == ChZ) begin
            taken = 4'd1;
            phase = PH_DONE;
          end else if (c == ChPlus || c == ChMinus) begin
            neg   = (c == ChMinus);
            phase = PH_H1;
          end else begin
            bad = 1'b1;
          end
        end
        PH_H1: begin
          if (dig) begin
            tens  = d;
            phase = PH_H2;
          end else begin
            bad = 1'b1;
          end
        end
        PH_H2: begin
          if (dig && two <= MaxHour) begin
            hours = two[HourW-1:0];
            taken = 4'd3;
            phase = PH_SEPM;
          end else begin
            bad = 1'b1;
          end
        end
        PH_SEPM, PH_SEPS: begin
          // a separator is consumed; otherwise this is already the tens digit
          if (colon_mode && c == ChColon) begin
            taken = taken + 4'd1;
            phase = phase_e'(phase + 4'd1);
          end else if (dig) begin
            tens  = d;
            phase = phase_e'(phase + 4'd2);
          end else begin
            phase = PH_DONE;
          end
        end
        PH_M1, PH_S1: begin
          if (dig) begin
            tens  = d;
            phase = phase_e'(phase + 4'd1);
          end else begin
            phase = PH_DONE;
          end
        end
        PH_M2: begin
          if (dig && two <= MaxMinSec) begin
            minutes = two[MinW-1:0];
            taken   = taken + 4'd2;
            phase   = PH_SEPS;
          end else begin
            phase = PH_DONE;
          end
        end
        PH_S2: begin
          if (dig && two <= MaxMinSec) begin
            seconds = two[SecW-1:0];
            taken   = taken + 4'd2;
          end
          phase = PH_DONE;
        end
        default: ;
      endcase
    end
    done = last;
    res  = '0;
    if (last) begin
      if (!bad && phase >= PH_SEPM) begin
        mag = (MagW'(hours) * 17'd60 + MagW'(minutes)) * 17'd60 + MagW'(seconds);
        off = {1'b0, mag};
        res.ok  = 1'b1;
        res.off = neg ? -off : off;
        res.cnt = taken;
      end
      clear_parse();
    end
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("MISMATCH at result %0d: %s is %0d, expected %0d", results_seen, field, got,
             want);
    errors++;
  endtask

  // Monitor: predict on every accepted character, check every accepted result.
  always @(posedge clk_i) begin
    offset_res_t   want;
    offset_res_t   got;
    typed_offset_t typed;
    logic          done;
    if (!rst_ni) begin
      clear_parse();
      colon_mode = 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        chars_seen++;
        parse_offset_char(s_axis_tdata_i, s_axis_tlast_i, done, want);
        if (done) begin
          if (typed_offsets.size() != 0) begin
            typed = typed_offsets.pop_front();
            if (typed.pinned) want = typed.res;
          end
          expected_offsets.insert(expected_offsets.size(), want);
        end
      end
      // a mode write applies from the next character on
      if (cfg_we_i) colon_mode = cfg_wdata_i;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.ok  = m_axis_tdata_o[0];
        got.off = m_axis_tdata_o[18:1];
        got.cnt = m_axis_tdata_o[22:19];
        if (expected_offsets.size() == 0) begin
          report_mismatch("result with nothing pending, tdata", int'(m_axis_tdata_o), 0);
        end else begin
          want = expected_offsets.pop_front();
          if (got.ok !== want.ok) report_mismatch("parse_ok", int'(got.ok), int'(want.ok));
          if (got.off !== want.off)
            report_mismatch("offset_seconds", int'($signed(got.off)), int'($signed(want.off)));
          if (got.cnt !== want.cnt)
            report_mismatch("chars_consumed", int'(got.cnt), int'(want.cnt));
          if (want.ok) ok_seen++;
        end
        results_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    do @(posedge clk_i); while (quiet_cycles < QuietLimit);
    $display("Timeout: no request moved for %0d cycles", QuietLimit);
    $display("Some tests failed");
    $finish;
  end

  // Result side: random stalls before each result while idle_on is set.
  initial begin
    int gap;
    @(posedge clk_i);
    forever begin
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  task automatic send_char(input logic [CharW-1:0] c, input logic last);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic send_text(input char_q_t text);
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
  endtask

  // Hold off until every pending result is out, then let the block settle.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (expected_offsets.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_colon_mode(input logic value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_now = value;
    mode_writes++;
  endtask

  task automatic push_two_digits(ref char_q_t text, input int max);
    int v;
    v = ($urandom_range(0, 7) != 0) ? $urandom_range(0, max) : $urandom_range(max + 1, 99);
    text.insert(text.size(), ChZero + CharW'(v / 10));
    text.insert(text.size(), ChZero + CharW'(v % 10));
  endtask

  task automatic push_separator(ref char_q_t text, input logic colon_on);
    if ($urandom_range(0, 9) < (colon_on ? 7 : 1)) text.insert(text.size(), ChColon);
  endtask

  // Mostly well-formed offsets, some noise, some broken or with trailing text.
  task automatic make_random_text(input logic colon_on, output char_q_t text);
    int kind;
    int keep;
    text = {};
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 6)) text.insert(text.size(), CharW'($urandom_range(0, 255)));
    end else if (kind < 14) begin
      text.insert(text.size(), ChZ);
    end else begin
      text.insert(text.size(), $urandom_range(0, 1) ? ChPlus : ChMinus);
      push_two_digits(text, 23);
      if ($urandom_range(0, 4) != 0) begin
        push_separator(text, colon_on);
        push_two_digits(text, 59);
        if ($urandom_range(0, 3) != 0) begin
          push_separator(text, colon_on);
          push_two_digits(text, 59);
        end
      end
    end
    if ($urandom_range(0, 6) == 0)
      text[$urandom_range(0, text.size() - 1)] = CharW'($urandom_range(0, 255));
    if ($urandom_range(0, 6) == 0) begin
      keep = $urandom_range(1, text.size());
      while (text.size() > keep) void'(text.pop_back());
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) text.insert(text.size(), CharW'($urandom_range(0, 255)));
  endtask

  initial begin
    char_q_t       text;
    typed_offset_t typed;
    int            phase_chars;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumDir; i++) begin
      typed.pinned  = (dir_ok[i] != Pred);
      typed.res.ok  = dir_ok[i] == 1;
      typed.res.off = OffW'(dir_off[i]);
      typed.res.cnt = CountW'(dir_cnt[i]);
      typed_offsets.insert(typed_offsets.size(), typed);
    end
    for (int i = 0; i < NumDir; i++) begin
      if (dir_colon[i] != cfg_now) begin
        drain_results();
        write_colon_mode(dir_colon[i]);
      end
      text = {};
      for (int j = 0; j < dir_txt[i].len(); j++) text.insert(text.size(), dir_txt[i][j]);
      send_text(text);
    end

    for (int p = 0; p < RandPhases; p++) begin
      drain_results();
      write_colon_mode(p % 2 == 0);
      idle_on = (p != 3);
      phase_chars = 0;
      while (phase_chars < PhaseChars) begin
        make_random_text(cfg_now, text);
        send_text(text);
        phase_chars += text.size();
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d characters and %0d results (%0d parsed ok), %0d colon mode writes,",
             chars_seen, results_seen, ok_seen, mode_writes);
    $display("directed and random strings, stalls on both sides and one phase without stalls.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
